// File: hw/rtl/ipv4hc_pkg.sv
// Shared types and constants for the IPv4 header checker.
`timescale 1ns / 1ps

package ipv4hc_pkg;

  localparam logic [3:0]  IpVersion4   = 4'd4;
  localparam logic [3:0]  MinHeaderLen = 4'd5;
  localparam logic [31:0] BcastAddr    = 32'hffff_ffff;
  localparam logic [5:0]  TtlByte      = 6'd8;
  localparam logic [4:0]  CsumWord     = 5'd5;
  localparam logic [5:0]  DestFirst    = 6'd16;
  localparam logic [5:0]  DestLast     = 6'd19;

  typedef enum logic [2:0] {
    VerdictAccept   = 3'd0,
    VerdictVersion  = 3'd1,
    VerdictHeadLen  = 3'd2,
    VerdictTtl      = 3'd3,
    VerdictDest     = 3'd4,
    VerdictChecksum = 3'd5
  } verdict_e;

  typedef struct packed {
    logic     valid;
    verdict_e verdict;
  } result_t;

endpackage

// File: hw/rtl/ipv4_header_checker.sv
// Top level of the IPv4 header checker: input register, check core, result register.
`timescale 1ns / 1ps
// An accepted byte waits in the input register until the result slot is free; its
// verdict is then registered in the result register.
// Throughput: one byte per cycle; the input register is refilled in the same
// cycle that its byte is processed, so only a stalled result slot holds input.
// Reset (asynchronous, active low) empties both registers, clears the local
// address, and leaves the checker idle until a byte flagged as first arrives.

module ipv4_header_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Byte stream.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  first_i,
  // Verdict stream.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ipv4hc_pkg::verdict_e  verdict_o,
  // Local address write port.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [31:0]           cfg_local_address_i
);
  import ipv4hc_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_first_q;
  logic        out_valid_q;
  verdict_e    verdict_q;
  logic [31:0] local_addr_q;

  logic        advance;
  logic        step;
  result_t     res;

  // The held byte is processed whenever the result slot is free or being
  // drained this cycle; a byte that yields no verdict simply passes through.
  assign advance     = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  // The address register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  ipv4hc_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .data_byte_i     (in_byte_q),
    .first_i         (in_first_q),
    .local_address_i (local_addr_q),
    .res_o           (res)
  );

  // Control state of both registers, and the local address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      local_addr_q <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= step && res.valid;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        local_addr_q <= cfg_local_address_i;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q  <= data_byte_i;
      in_first_q <= first_i;
    end
    if (step && res.valid) begin
      verdict_q <= res.verdict;
    end
  end

  // Input is held back only by a verdict that is waiting to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && in_valid_q))
    else $error("input stalled without a pending verdict");

  // A stalled verdict is never overwritten by a new one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !step)
    else $error("core stepped while verdict pending");

endmodule

// File: hw/rtl/ipv4hc_core.sv
// Per-byte header state and check logic of the IPv4 header checker.
`timescale 1ns / 1ps

module ipv4hc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 first_i,
  input  logic [31:0]          local_address_i,
  output ipv4hc_pkg::result_t  res_o
);
  import ipv4hc_pkg::*;

  logic [5:0]  byte_index_q, byte_index_d;
  logic [3:0]  header_words_q, header_words_d;
  logic [15:0] word_sum_q, word_sum_d;
  logic [7:0]  high_byte_q, high_byte_d;
  logic [31:0] dest_accum_q, dest_accum_d;
  logic [15:0] rx_csum_q, rx_csum_d;
  logic        verdict_done_q, verdict_done_d;

  logic [5:0]  idx;
  logic [3:0]  hw_cur;
  logic [15:0] sum_cur;
  logic [7:0]  high_cur;
  logic [31:0] dest_cur;
  logic [15:0] csum_cur;
  logic        done_cur;
  logic [15:0] word;
  logic [16:0] sum_wide;
  logic [15:0] sum_fold;
  logic [5:0]  last_idx;

  always_comb begin
    // A first byte restarts the packet, so the current state is the cleared one.
    idx      = first_i ? '0 : byte_index_q;
    hw_cur   = first_i ? '0 : header_words_q;
    sum_cur  = first_i ? '0 : word_sum_q;
    high_cur = first_i ? '0 : high_byte_q;
    dest_cur = first_i ? '0 : dest_accum_q;
    csum_cur = first_i ? '0 : rx_csum_q;
    done_cur = first_i ? 1'b0 : verdict_done_q;

    word     = {high_cur, data_byte_i};
    sum_wide = {1'b0, sum_cur} + {1'b0, word};
    sum_fold = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];

    header_words_d = (idx == '0) ? data_byte_i[3:0] : hw_cur;
    dest_accum_d   = (idx >= DestFirst && idx <= DestLast) ?
                     {dest_cur[23:0], data_byte_i} : dest_cur;
    high_byte_d    = idx[0] ? high_cur : data_byte_i;
    rx_csum_d      = csum_cur;
    word_sum_d     = sum_cur;
    if (idx[0]) begin
      if (idx[5:1] == CsumWord) begin
        rx_csum_d = word;
      end else begin
        word_sum_d = sum_fold;
      end
    end

    last_idx = {header_words_d - 4'd1, 2'b11};

    res_o.valid   = 1'b0;
    res_o.verdict = VerdictAccept;
    if (!done_cur) begin
      if (idx == '0 && data_byte_i[7:4] != IpVersion4) begin
        res_o.valid   = 1'b1;
        res_o.verdict = VerdictVersion;
      end else if (idx == '0 && data_byte_i[3:0] < MinHeaderLen) begin
        res_o.valid   = 1'b1;
        res_o.verdict = VerdictHeadLen;
      end else if (idx == TtlByte && data_byte_i == '0) begin
        res_o.valid   = 1'b1;
        res_o.verdict = VerdictTtl;
      end else if (idx == DestLast && dest_accum_d != local_address_i &&
                   dest_accum_d != BcastAddr) begin
        res_o.valid   = 1'b1;
        res_o.verdict = VerdictDest;
      end else if (idx == last_idx) begin
        res_o.valid   = 1'b1;
        res_o.verdict = (~word_sum_d != rx_csum_d) ? VerdictChecksum : VerdictAccept;
      end
    end

    verdict_done_d = done_cur | res_o.valid;
    byte_index_d   = (done_cur || res_o.valid) ? idx : idx + 6'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q   <= '0;
      header_words_q <= '0;
      word_sum_q     <= '0;
      high_byte_q    <= '0;
      dest_accum_q   <= '0;
      rx_csum_q      <= '0;
      verdict_done_q <= 1'b1;
    end else if (step_i) begin
      byte_index_q   <= byte_index_d;
      header_words_q <= header_words_d;
      word_sum_q     <= word_sum_d;
      high_byte_q    <= high_byte_d;
      dest_accum_q   <= dest_accum_d;
      rx_csum_q      <= rx_csum_d;
      verdict_done_q <= verdict_done_d;
    end
  end

  // A verdict closes the packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid |=> verdict_done_q)
    else $error("verdict did not close the packet");

  // A closed packet stays silent until the next first byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && verdict_done_q && !first_i |-> !res_o.valid)
    else $error("result after verdict");

  // An open packet never runs past the longest header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !verdict_done_q |-> byte_index_q < 6'd60)
    else $error("byte index past header end");

endmodule

// File: test/ipv4_verdict_check.sv
// Checker for the IPv4 header checker: predicts each verdict and compares it with the block.
`timescale 1ns / 1ps

module ipv4_verdict_check (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 first_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  ipv4hc_pkg::verdict_e verdict_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [31:0]          cfg_local_address_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   checked_o
);

  import ipv4hc_pkg::*;

  logic [31:0] host_addr;
  logic        in_header;
  logic [5:0]  hdr_pos;
  logic [3:0]  hdr_words;
  logic [19:0] csum_acc;
  logic [7:0]  upper_byte;
  logic [31:0] dest_addr;
  logic [15:0] csum_field;
  verdict_e    verdicts_due[$];
  verdict_e    oldest;

  // Advances the header state by one byte and queues a verdict when one is decided.
  task automatic judge_byte(input logic [7:0] b, input logic f);
    logic        decided;
    verdict_e    v;
    logic [15:0] folded;
    decided = 1'b0;
    v = VerdictAccept;
    if (f) begin
      in_header = 1'b1;
      hdr_pos = '0;
      hdr_words = '0;
      csum_acc = '0;
      upper_byte = '0;
      dest_addr = '0;
      csum_field = '0;
    end
    if (in_header) begin
      if (hdr_pos == '0) begin
        if (b[7:4] != IpVersion4) begin
          decided = 1'b1;
          v = VerdictVersion;
        end else if (b[3:0] < MinHeaderLen) begin
          decided = 1'b1;
          v = VerdictHeadLen;
        end else begin
          hdr_words = b[3:0];
        end
      end
      if (!decided && hdr_pos == TtlByte && b == 8'h00) begin
        decided = 1'b1;
        v = VerdictTtl;
      end
      if (!decided) begin
        if (hdr_pos >= DestFirst && hdr_pos <= DestLast) dest_addr = {dest_addr[23:0], b};
        if (!hdr_pos[0]) begin
          upper_byte = b;
        end else if (hdr_pos[5:1] == CsumWord) begin
          csum_field = {upper_byte, b};
        end else begin
          // Ones' complement add with the carry wrapped back in.
          csum_acc = csum_acc + {4'h0, upper_byte, b};
          if (csum_acc > 20'h0ffff) csum_acc = {4'h0, csum_acc[15:0]} + {16'h0, csum_acc[19:16]};
        end
        folded = ~csum_acc[15:0];
        if (hdr_pos == DestLast && dest_addr != host_addr && dest_addr != BcastAddr) begin
          decided = 1'b1;
          v = VerdictDest;
        end else if (int'(hdr_pos) == 4 * int'(hdr_words) - 1) begin
          decided = 1'b1;
          v = (folded == csum_field) ? VerdictAccept : VerdictChecksum;
        end else begin
          hdr_pos = hdr_pos + 6'd1;
        end
      end
      if (decided) begin
        in_header = 1'b0;
        verdicts_due.push_back(v);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_addr = '0;
      in_header = 1'b0;
      hdr_pos = '0;
      hdr_words = '0;
      csum_acc = '0;
      upper_byte = '0;
      dest_addr = '0;
      csum_field = '0;
      verdicts_due.delete();
      errors_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict: expected none, actual %0d", verdict_i);
          errors_o++;
        end else begin
          oldest = verdicts_due.pop_front();
          checked_o++;
          if (verdict_i !== oldest) begin
            $error("verdict: expected %0d, actual %0d", oldest, verdict_i);
            errors_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) host_addr = cfg_local_address_i;
      if (in_valid_i && in_ready_i) judge_byte(data_byte_i, first_i);
      pending_o = verdicts_due.size();
    end
  end

endmodule

// File: test/ipv4_header_checker_test.sv
// Testbench top for the IPv4 header checker: byte stimulus, result stalls and the final verdict.
`timescale 1ns / 1ps

module ipv4_header_checker_test;

  import ipv4hc_pkg::*;

  // A taken byte passes the input register and then the result register; the drain wait covers that path.
  localparam int CycleLimit          = 400000;
  localparam int DrainCycles         = 8;
  localparam int RandomBytesPerPhase = 140;

  // Shapes of packet the stimulus can build. Most error kinds break one check; a bad destination
  // also fails the checksum. The predicted verdict usually follows the kind; the checker decides alone.
  typedef enum int {
    PktGood, PktBadVersion, PktBadIhl, PktTtlZero,
    PktBadDest, PktBadCsum, PktTruncated, PktNoise
  } pkt_kind_e;

  // Where a well-formed packet is addressed.
  typedef enum int {DstLocal, DstBcast, DstAny} dst_sel_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        first_i;
  logic        out_valid_o;
  logic        out_ready_i;
  verdict_e    verdict_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_local_address_i;

  int          errors;
  int          pending;
  int          checked;
  int          cycles;
  int          burst_left;
  int          bytes_sent;
  int          packets;
  int          cfg_writes;
  logic [31:0] local_addr;

  ipv4_header_checker uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .data_byte_i         (data_byte_i),
    .first_i             (first_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .verdict_o           (verdict_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_local_address_i (cfg_local_address_i)
  );

  ipv4_verdict_check u_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .data_byte_i         (data_byte_i),
    .first_i             (first_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .verdict_i           (verdict_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_local_address_i (cfg_local_address_i),
    .errors_o            (errors),
    .pending_o           (pending),
    .checked_o           (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // A hung handshake or a lost verdict ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The verdict receiver switches between stall patterns of random length: always ready,
  // coin flips, mostly stalled, and a fixed one-in-three rhythm.
  initial begin
    int mode;
    int left;
    out_ready_i = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = 1'($urandom_range(0, 1));
        2: out_ready_i = ($urandom_range(0, 5) == 0);
        default: out_ready_i = (left % 3 == 0);
      endcase
    end
  end

  // Offers one byte request and returns at the falling edge after it is taken. Valid
  // stays high on return so that back-to-back bytes never drop it; a gap between
  // bursts lowers it here, at the start of the next request.
  task automatic send_byte(input logic [7:0] b, input logic f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    data_byte_i = b;
    first_i = f;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // Changes the local address once every verdict is in and the pipeline has had time
  // to finish any byte that produced no verdict.
  task automatic write_address(input logic [31:0] addr);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_local_address_i = addr;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    local_addr = addr;
    cfg_writes++;
  endtask

  // Builds a header with random content and a correct checksum, then breaks it as the
  // kind asks. Some packets carry trailing payload bytes that the block must ignore.
  task automatic send_packet(input pkt_kind_e kind, input int ihl, input dst_sel_e dst_sel);
    logic [7:0]  hdr [0:59];
    logic [31:0] dst;
    logic [31:0] acc;
    logic [15:0] csum;
    int          nbytes;
    int          pos;
    for (int i = 0; i < 60; i++) hdr[i] = 8'($urandom);
    hdr[0] = {IpVersion4, 4'(ihl)};
    if (hdr[8] == 8'h00) hdr[8] = 8'h40;
    case (dst_sel)
      DstLocal: dst = local_addr;
      DstBcast: dst = BcastAddr;
      default: dst = ($urandom_range(0, 2) == 0) ? BcastAddr : local_addr;
    endcase
    {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
    acc = '0;
    for (int w = 0; w < 2 * ihl; w++) begin
      if (w != int'(CsumWord)) begin
        acc = acc + {16'h0, hdr[2 * w], hdr[2 * w + 1]};
        acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
      end
    end
    csum = ~acc[15:0];
    {hdr[10], hdr[11]} = csum;
    nbytes = 4 * ihl;
    case (kind)
      PktBadVersion: begin
        do hdr[0][7:4] = 4'($urandom); while (hdr[0][7:4] == IpVersion4);
        nbytes = $urandom_range(1, 5);
      end
      PktBadIhl: begin
        hdr[0][3:0] = 4'($urandom_range(0, 4));
        nbytes = $urandom_range(1, 5);
      end
      PktTtlZero: begin
        hdr[8] = 8'h00;
        nbytes = $urandom_range(9, nbytes);
      end
      PktBadDest: begin
        // The checksum was taken over the good address, so with a five-word header
        // the address and the checksum both fail on the same byte.
        do dst = $urandom; while (dst == local_addr || dst == BcastAddr);
        {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
      end
      PktBadCsum: begin
        do pos = $urandom_range(1, nbytes - 1); while (pos == 8 || (pos >= 16 && pos <= 19));
        hdr[pos] = hdr[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      PktTruncated: nbytes = $urandom_range(1, nbytes - 1);
      PktNoise: nbytes = 0;
      default: ;
    endcase
    for (int i = 0; i < nbytes; i++) send_byte(hdr[i], i == 0);
    if (kind == PktNoise || $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
    end
    packets++;
  endtask

  initial begin
    pkt_kind_e   kind;
    int          ihl;
    int          r;
    int          mark;
    logic [31:0] phase_addr;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    first_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_local_address_i = '0;
    local_addr = '0;
    burst_left = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Bytes before any first byte are dropped, then single-byte packets
    // hit the version check (versions 15 and 0) and the header length check (0 and 4).
    write_address(32'hc0a8_0001);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hf5, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h40, 1'b1);
    send_byte(8'h44, 1'b1);
    // Zero TTL, plain accepts at the shortest and the longest header, a wrong
    // destination that also breaks the checksum, a corrupt checksum, and a header cut
    // short by the next packet's first byte.
    send_packet(PktTtlZero, 5, DstLocal);
    send_packet(PktGood, 5, DstLocal);
    send_packet(PktGood, 15, DstBcast);
    send_packet(PktBadDest, 5, DstLocal);
    send_packet(PktBadCsum, 6, DstLocal);
    send_packet(PktTruncated, 5, DstLocal);
    send_packet(PktGood, 5, DstBcast);

    // Random part, one phase per local address: the directed one, then all ones (the
    // broadcast value itself), all zeros and two random addresses. Most headers are
    // short; about one in five uses options up to the largest length.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: phase_addr = 32'hffff_ffff;
          2: phase_addr = 32'h0000_0000;
          default: phase_addr = $urandom;
        endcase
        write_address(phase_addr);
      end
      mark = bytes_sent;
      while (bytes_sent < mark + RandomBytesPerPhase) begin
        r = $urandom_range(0, 99);
        ihl = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 15) : $urandom_range(5, 7);
        if (r < 35) kind = PktGood;
        else if (r < 50) kind = PktBadCsum;
        else if (r < 60) kind = PktTruncated;
        else if (r < 68) kind = PktTtlZero;
        else if (r < 76) kind = PktBadVersion;
        else if (r < 84) kind = PktBadIhl;
        else if (r < 92) kind = PktBadDest;
        else kind = PktNoise;
        send_packet(kind, ihl, DstAny);
      end
    end

    // Let every predicted verdict arrive, then watch a little longer for strays.
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d bytes in %0d packets under %0d local addresses; %0d verdicts checked.",
             bytes_sent, packets, cfg_writes, checked);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ipv4hc_pkg.sv
hw/rtl/ipv4hc_core.sv
hw/rtl/ipv4_header_checker.sv
test/ipv4_verdict_check.sv
test/ipv4_header_checker_test.sv
